// ----- src/route_table_add_update_delete_defines.svh -----
// ----------------------------------------------------------------------------
// Route table assertion macros
// Shared property shorthands for the route table checker.
// ----------------------------------------------------------------------------
`ifndef ROUTE_TABLE_ADD_UPDATE_DELETE_DEFINES_SVH
`define ROUTE_TABLE_ADD_UPDATE_DELETE_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent
`define RT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequent in the cycle after its antecedent
`define RT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/rtaud_pkg.sv -----
// ----------------------------------------------------------------------------
// Route table package
// Action and status codes, entry layout and controller/datapath interface.
// ----------------------------------------------------------------------------
package rtaud_pkg;

   // Action codes carried on req_tuser
   localparam logic [1:0] ACT_ADD    = 2'd0;
   localparam logic [1:0] ACT_UPDATE = 2'd1;
   localparam logic [1:0] ACT_DELETE = 2'd2;

   // Result status codes
   localparam logic [1:0] ST_DONE      = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;

   // Beat widths
   localparam int REQ_DATA_W = 136;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 8;
   localparam int COUNT_OUT_W = 5;

   // One stored route
   typedef struct packed {
      logic [31:0] dest;
      logic [31:0] mask;
      logic [31:0] gateway;
      logic [7:0]  port;
   } entry_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic       load;
      logic       scan;
      logic       save_slot;
      logic       add_wr;
      logic       upd_wr;
      logic       del_rd;
      logic       del_wr;
      logic       status_en;
      logic [1:0] status;
      logic       rsp_load;
   } ctl_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic hit;
      logic scan_end;
      logic full;
   } dp_sts_type;

endpackage

// ----- src/route_table_add_update_delete.sv -----
// ----------------------------------------------------------------------------
// Route table with add, update and delete
// Unordered table of up to ENTRIES routes; delete moves the last entry down.
// ----------------------------------------------------------------------------
//  channel | direction | fields (low bit first)
//  req     | in        | tuser: action; tdata: match_key, entry_destination,
//          |           |        entry_mask, entry_gateway, entry_port
//  rsp     | out       | tdata: status, entry_count, one zero pad bit
//
//  An add goes through S_ADD to S_DONE; an unused action goes straight to S_DONE.
//  Update and delete scan one entry a cycle on the single read port, and a
//  miss ends when the scan reaches the entry count; a delete hit then passes
//  through S_DEL_RD and S_DEL_WR to move the last entry down.
//  One beat in work at a time; the next request is taken while a result waits
//  for rsp_tready, and a newer result holds until then. Reset empties the table.
// ----------------------------------------------------------------------------
module route_table_add_update_delete #(
   parameter int ENTRIES = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // match_key[31:0], entry_destination[63:32], entry_mask[95:64],
   // entry_gateway[127:96], entry_port[135:128]
   input  logic [rtaud_pkg::REQ_DATA_W-1:0] req_tdata,
   // action[1:0]
   input  logic [rtaud_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // status[1:0], entry_count[6:2], zero[7]
   output logic [rtaud_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import rtaud_pkg::*;

   ctl_cmd_type cmd;
   dp_sts_type  sts;

   // Sequencer
   rtaud_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   // Table storage and compare
   rtaud_dp #(
      .ENTRIES (ENTRIES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_tdata (rsp_tdata)
   );

endmodule

// ----- src/rtaud_dp.sv -----
// ----------------------------------------------------------------------------
// Route table datapath
// Entry memory, scan pointer, compare, entry count and result register.
// ----------------------------------------------------------------------------
module rtaud_dp #(
   parameter int ENTRIES = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [rtaud_pkg::REQ_DATA_W-1:0] req_tdata,
   input  rtaud_pkg::ctl_cmd_type          cmd,
   output rtaud_pkg::dp_sts_type           sts,
   output logic [rtaud_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import rtaud_pkg::*;

   localparam int IW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);

   entry_type           mem_ff [ENTRIES];
   entry_type           rd_data_ff;
   entry_type           new_ff;
   logic [31:0]         key_ff;
   logic                rd_vld_ff, rd_vld_in;
   logic [CW-1:0]       scan_ff, scan_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [IW-1:0]       cmp_idx_ff;
   logic [IW-1:0]       slot_ff;
   logic [1:0]          status_ff;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff;

   logic                issue;
   logic                rd_en;
   logic [IW-1:0]       rd_addr;
   logic [CW-1:0]       count_m1;
   logic                wr_en;
   logic [IW-1:0]       wr_addr;
   entry_type           wr_data;
   logic [CW+4:0]       count_ext;

   // Read port: scan pointer, or last entry for a delete
   assign issue    = cmd.scan && (scan_ff != count_ff);
   assign count_m1 = count_ff - CW'(1);
   assign rd_en    = issue || cmd.del_rd;
   assign rd_addr  = cmd.del_rd ? count_m1[IW-1:0] : scan_ff[IW-1:0];

   // Write port: append, overwrite in place, or move last into freed slot
   assign wr_en   = cmd.add_wr || cmd.upd_wr || cmd.del_wr;
   assign wr_addr = cmd.add_wr ? count_ff[IW-1:0] :
                    cmd.upd_wr ? cmp_idx_ff : slot_ff;
   assign wr_data = cmd.del_wr ? rd_data_ff : new_ff;

   // Entry memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   // Next values of the control counters
   always_comb begin
      rd_vld_in = issue;
      scan_in   = scan_ff;
      if (cmd.load) begin
         scan_in = '0;
      end else if (issue) begin
         scan_in = scan_ff + CW'(1);
      end
      count_in = count_ff;
      if (cmd.add_wr) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.del_wr) begin
         count_in = count_m1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
         scan_ff   <= '0;
         count_ff  <= '0;
      end else begin
         rd_vld_ff <= rd_vld_in;
         scan_ff   <= scan_in;
         count_ff  <= count_in;
      end
   end

   // Latch the request beat and track scan addresses
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff          <= req_tdata[31:0];
         new_ff.dest     <= req_tdata[63:32];
         new_ff.mask     <= req_tdata[95:64];
         new_ff.gateway  <= req_tdata[127:96];
         new_ff.port     <= req_tdata[135:128];
      end
      if (issue) begin
         cmp_idx_ff <= scan_ff[IW-1:0];
      end
      if (cmd.save_slot) begin
         slot_ff <= cmp_idx_ff;
      end
      if (cmd.status_en) begin
         status_ff <= cmd.status;
      end
      if (cmd.rsp_load) begin
         rsp_tdata_ff <= {1'b0, count_ext[COUNT_OUT_W-1:0], status_ff};
      end
   end

   assign count_ext = {5'b0, count_ff};

   // Status back to the controller
   assign sts.hit      = rd_vld_ff && (rd_data_ff.dest == key_ff);
   assign sts.scan_end = !rd_vld_ff && (scan_ff == count_ff);
   assign sts.full     = (count_ff == CW'(ENTRIES));

   assign rsp_tdata = rsp_tdata_ff;

endmodule

// ----- src/rtaud_ctrl.sv -----
// ----------------------------------------------------------------------------
// Route table controller
// Sequences add, scan, update and delete, and owns both handshakes.
// ----------------------------------------------------------------------------
module rtaud_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [rtaud_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output rtaud_pkg::ctl_cmd_type           cmd,
   input  rtaud_pkg::dp_sts_type            sts
);
   import rtaud_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_ADD    = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_DEL_RD = 3'd3;
   localparam logic [2:0] S_DEL_WR = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [1:0] action_ff, action_in;
   logic       rsp_tvalid_ff, rsp_tvalid_in;

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      action_in  = action_ff;
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load  = 1'b1;
               action_in = req_tuser;
               case (req_tuser)
                  ACT_ADD:    state_in = S_ADD;
                  ACT_UPDATE: state_in = S_SCAN;
                  ACT_DELETE: state_in = S_SCAN;
                  default: begin
                     cmd.status_en = 1'b1;
                     cmd.status    = ST_DONE;
                     state_in      = S_DONE;
                  end
               endcase
            end
         end
         S_ADD: begin
            cmd.status_en = 1'b1;
            if (sts.full) begin
               cmd.status = ST_FULL;
            end else begin
               cmd.add_wr = 1'b1;
               cmd.status = ST_DONE;
            end
            state_in = S_DONE;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.hit) begin
               if (action_ff == ACT_DELETE) begin
                  cmd.save_slot = 1'b1;
                  state_in      = S_DEL_RD;
               end else begin
                  cmd.upd_wr    = 1'b1;
                  cmd.status_en = 1'b1;
                  cmd.status    = ST_DONE;
                  state_in      = S_DONE;
               end
            end else if (sts.scan_end) begin
               cmd.status_en = 1'b1;
               cmd.status    = ST_NOT_FOUND;
               state_in      = S_DONE;
            end
         end
         S_DEL_RD: begin
            cmd.del_rd = 1'b1;
            state_in   = S_DEL_WR;
         end
         S_DEL_WR: begin
            cmd.del_wr    = 1'b1;
            cmd.status_en = 1'b1;
            cmd.status    = ST_DONE;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold the result beat until taken
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (cmd.rsp_load) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         action_ff     <= ACT_ADD;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         action_ff     <= action_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;

endmodule

// ----- src/rtaud_checker.sv -----
// ----------------------------------------------------------------------------
// Route table port checker
// Watches the top level's ports for handshake and sequencing slips.
// ----------------------------------------------------------------------------
`include "route_table_add_update_delete_defines.svh"

module rtaud_checker #(
   parameter int ENTRIES = 16
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [rtaud_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import rtaud_pkg::*;

   localparam logic [4:0] FULL_COUNT = 5'(ENTRIES);

   // Result beat holds while stalled
   `RT_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid, "rsp beat dropped")
   `RT_ASSERT_NEXT(a_rsp_stable, rsp_tvalid && !rsp_tready, $stable(rsp_tdata), "rsp data moved")

   // One request in work at a time
   `RT_ASSERT_NEXT(a_one_busy, req_tvalid && req_tready, !req_tready, "second beat taken")

   // No result can appear the cycle after a request is taken
   `RT_ASSERT_NEXT(a_min_lat, req_tvalid && req_tready, !$rose(rsp_tvalid), "result too early")

   // A full status reports a full table
   `RT_ASSERT_NOW(a_full_cnt, rsp_tvalid && (rsp_tdata[1:0] == ST_FULL), rsp_tdata[6:2] == FULL_COUNT, "full with room")

endmodule

bind route_table_add_update_delete rtaud_checker #(
   .ENTRIES (ENTRIES)
) u_rtaud_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- tb/route_table_add_update_delete_tb.sv -----
// ----------------------------------------------------------------------------
// Route table testbench
// Drives add, update, delete and unused-action beats into the route table and
// checks every response against a shadow copy of the table kept in a small
// scoreboard class. A directed opener covers empty and full tables, boundary
// field values and deletes of the last slot. A random run follows, with
// matching keys drawn from the shadow table, and with three back-pressure
// phases on the request and response channels.
// ----------------------------------------------------------------------------
module route_table_add_update_delete_tb;
   import rtaud_pkg::*;

   localparam int          TABLE_DEPTH  = 16;
   localparam int          RANDOM_BEATS = 1600;
   localparam int          CYCLE_LIMIT  = 400_000;
   localparam int          DRAIN_CYCLES = 40;
   localparam logic [1:0]  ACT_UNUSED   = 2'd3;

   // One expected response
   typedef struct packed {
      logic [1:0] status;
      logic [4:0] count;
   } route_result_type;

   // Shadow route table and queue of expected responses
   class route_table_shadow_type;
      entry_type        routes[TABLE_DEPTH];
      int               count;
      route_result_type expected_results[$];
      int               failures;

      function new();
         count    = 0;
         failures = 0;
      endfunction

      // First live slot whose destination equals key, or -1
      function int find_slot(logic [31:0] key);
         for (int i = 0; i < count; i++) begin
            if (routes[i].dest == key) return i;
         end
         return -1;
      endfunction

      // Destination of a random live slot; table must not be empty
      function logic [31:0] stored_dest();
         return routes[$urandom_range(count - 1)].dest;
      endfunction

      function logic [31:0] last_dest();
         return routes[count - 1].dest;
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      // Apply an accepted request beat and queue its response
      function void note_request(logic [1:0] action, logic [31:0] key, entry_type ent);
         route_result_type res;
         int               slot;
         res.status = ST_DONE;
         slot       = find_slot(key);
         case (action)
            ACT_ADD: begin
               if (count < TABLE_DEPTH) begin
                  routes[count] = ent;
                  count++;
               end else begin
                  res.status = ST_FULL;
               end
            end
            ACT_UPDATE: begin
               if (slot >= 0) routes[slot] = ent;
               else res.status = ST_NOT_FOUND;
            end
            ACT_DELETE: begin
               // move the last entry into the hole, possibly onto itself
               if (slot >= 0) begin
                  routes[slot] = routes[count - 1];
                  count--;
               end else begin
                  res.status = ST_NOT_FOUND;
               end
            end
            default: ;
         endcase
         res.count = 5'(count);
         expected_results.push_back(res);
      endfunction

      // Compare a response beat with the oldest expectation
      function void check_response(logic [1:0] status, logic [4:0] resp_count);
         route_result_type res;
         if (expected_results.size() == 0) begin
            $error("response beat with no request pending: status %0d, entry_count %0d",
                   status, resp_count);
            failures++;
            return;
         end
         res = expected_results.pop_front();
         if (status !== res.status) begin
            $error("status mismatch: expected %0d, actual %0d", res.status, status);
            failures++;
         end
         if (resp_count !== res.count) begin
            $error("entry_count mismatch: expected %0d, actual %0d", res.count, resp_count);
            failures++;
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic [REQ_USER_W-1:0]  req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;

   int                     req_idle_pct = 23;
   int                     rsp_idle_pct = 78;
   int                     cycle_count  = 0;
   logic [31:0]            key_pool[10];
   route_table_shadow_type book = new();

   route_table_add_update_delete #(
      .ENTRIES(TABLE_DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Stall the response channel at random
   always @(negedge clock) begin
      rsp_tready <= !reset && ($urandom_range(99) >= rsp_idle_pct);
   end

   // Check every accepted response beat
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         book.check_response(rsp_tdata[1:0], rsp_tdata[6:2]);
      end
   end

   // Watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("== FAIL ==");
      $finish;
   end

   // Send one request beat; called and returns at a falling edge
   task automatic send_request(logic [1:0] action, logic [31:0] key, entry_type ent);
      if ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= {ent.port, ent.gateway, ent.mask, ent.dest, key};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      book.note_request(action, key, ent);
      @(negedge clock);
   endtask

   function automatic entry_type make_entry(logic [31:0] dest);
      entry_type ent;
      ent.dest    = dest;
      ent.mask    = $urandom;
      ent.gateway = $urandom;
      ent.port    = 8'($urandom_range(255));
      return ent;
   endfunction

   // Random request mixing fill and drain stretches
   task automatic send_random(bit fill);
      logic [1:0]  action;
      logic [31:0] key;
      logic [31:0] dest;
      int          pick;
      pick = $urandom_range(99);
      if (pick < (fill ? 55 : 20))      action = ACT_ADD;
      else if (pick < (fill ? 75 : 55)) action = ACT_UPDATE;
      else if (pick < 95)               action = ACT_DELETE;
      else                              action = ACT_UNUSED;
      // aim most searches at live entries so hits dominate
      if (book.count > 0 && $urandom_range(99) < 75) key = book.stored_dest();
      else if ($urandom_range(1))                    key = key_pool[$urandom_range(9)];
      else                                           key = $urandom;
      dest = ($urandom_range(99) < 70) ? key_pool[$urandom_range(9)] : $urandom;
      send_request(action, key, make_entry(dest));
   endtask

   initial begin
      entry_type ent;
      key_pool[0] = 32'h0000_0000;
      key_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < 10; i++) key_pool[i] = $urandom;

      // hold reset, then release at a falling edge
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty table: searches miss, unused action changes nothing
      send_request(ACT_UPDATE, 32'h0000_0000, make_entry(32'h1234_5678));
      send_request(ACT_DELETE, 32'hFFFF_FFFF, make_entry(32'h1234_5678));
      send_request(ACT_UNUSED, 32'h0000_0000, make_entry(32'h0000_0000));

      // boundary entries, then fill to capacity
      ent = '0;
      send_request(ACT_ADD, 32'hFFFF_FFFF, ent);
      ent = '1;
      send_request(ACT_ADD, 32'h0000_0000, ent);
      for (int i = 0; i < TABLE_DEPTH - 2; i++) begin
         send_request(ACT_ADD, $urandom, make_entry(32'(i + 100)));
      end

      // full table: add refused, unused still reports count
      send_request(ACT_ADD, 32'h0000_0000, make_entry(32'hAAAA_5555));
      send_request(ACT_UNUSED, 32'hFFFF_FFFF, make_entry(32'h5555_AAAA));

      // update hit, delete from the front, delete of the last slot, miss
      send_request(ACT_UPDATE, 32'hFFFF_FFFF, make_entry(32'h0F0F_0F0F));
      send_request(ACT_DELETE, 32'h0000_0000, make_entry(32'h0000_0000));
      send_request(ACT_DELETE, book.last_dest(), make_entry(32'h0000_0000));
      send_request(ACT_UPDATE, 32'hDEAD_BEEF, make_entry(32'h0000_0001));

      // random traffic in three back-pressure phases
      for (int i = 0; i < RANDOM_BEATS; i++) begin
         if (i == RANDOM_BEATS / 3) begin
            req_idle_pct = 78;
            rsp_idle_pct = 23;
         end else if (i == 2 * RANDOM_BEATS / 3) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         send_random(((i / 60) % 2) == 0);
      end
      req_tvalid <= 1'b0;

      // drain outstanding responses, then let the pipeline settle
      while (book.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (book.failures == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+src
src/rtaud_pkg.sv
src/rtaud_dp.sv
src/rtaud_ctrl.sv
src/route_table_add_update_delete.sv
src/rtaud_checker.sv
tb/route_table_add_update_delete_tb.sv
